// ----- design/vmd_pkg.sv -----
package vmd_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int SAMPLE_W     = 16;
  localparam int SINE_DEPTH   = 256;
  localparam int SINE_IDX_W   = $clog2(SINE_DEPTH);
  localparam int QUARTER      = SINE_DEPTH / 4;
  localparam int Q_IDX_W      = $clog2(QUARTER);
  localparam int SINE_W       = 16;
  localparam int PHASE_W      = 32;
  localparam int DEPTH_CFG_W  = 14;
  localparam int FRAC_W       = 8;
  localparam int DELAY_MIN    = 1 << FRAC_W;
  localparam int DELAY_MAX    = (BUFFER_DEPTH - 1) << FRAC_W;
  localparam int DELAY_W      = $clog2(DELAY_MAX + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_BASE_DELAY = 2'd1,
    CFG_MOD_DEPTH  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DELAY,
    S_READ_OLD,
    S_INTERP
  } state_e;

  typedef logic [SINE_W-2:0] quarter_tab_t [QUARTER+1];

  typedef longint unsigned taylor_div_t [6];
  localparam taylor_div_t TAYLOR_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Quarter-wave sine in Q1.15, built from a Taylor series in Q30 at elaboration.
  function automatic quarter_tab_t build_quarter();
    quarter_tab_t    tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    int              i;
    int              k;
    for (i = 0; i <= QUARTER; i++) begin
      x    = (64'(i) * HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
        if ((k % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
      tab[i] = (SINE_W-1)'(r);
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER_SINE = build_quarter();

endpackage

// ----- design/vibrato_modulated_delay_core.sv -----
// Vibrato: each sample item is delayed by a fractional amount swept by a sine LFO
// and the two neighboring stored samples are interpolated linearly. The next item is
// accepted only once the current one has written its sample back, so the block does
// not take a new item while one is in flight; the sequence is the sine lookup, the
// depth multiply, the delay sum, and two reads through the single read port of the
// delay memory before the interpolation. After reset the delay memory reads as zero
// through per-entry valid flags, so no clearing pass is needed. A waiting result does
// not block the next item's start.
module vibrato_modulated_delay_core
  import vmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: sample_in.
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,
  // Fields from bit 0: restart_lfo.
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: sample_out.
  output logic [SAMPLE_W-1:0]   m_axis_tdata
);

  localparam int PROD_W = SINE_W + DEPTH_CFG_W + 1;
  localparam int DSUM_W = SINE_W + 1;
  localparam int ACC_W  = SAMPLE_W + FRAC_W + 2;

  state_e state_q, state_d;

  logic [PHASE_W-1:0]     phase_step_q;
  logic [DEPTH_CFG_W-1:0] base_delay_q;
  logic [DEPTH_CFG_W-1:0] mod_depth_q;
  logic [PHASE_W-1:0]     lfo_phase_q;
  logic [ADDR_W-1:0]      wp_q;
  logic [BUFFER_DEPTH-1:0] valid_q;

  logic [SAMPLE_W-1:0]      sample_q;
  logic signed [SINE_W-1:0] sine_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [FRAC_W-1:0]        frac_q;
  logic [ADDR_W-1:0]        old_addr_q;
  logic signed [SAMPLE_W-1:0] newer_q;
  logic                     rd_valid_q;
  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      out_data_q;

  logic                  accept;
  logic                  load_out;
  logic                  ram_rd_en;
  logic [ADDR_W-1:0]     ram_rd_addr;
  logic                  ram_we;
  logic [SAMPLE_W-1:0]   ram_rd_data;
  logic signed [SAMPLE_W-1:0] rd_sample;

  logic [PHASE_W-1:0]       phase_used;
  logic [SINE_IDX_W-1:0]    sine_n;
  logic [1:0]               quad;
  logic [Q_IDX_W:0]         tab_idx;
  logic signed [SINE_W-1:0] sine_mag;
  logic signed [SINE_W-1:0] sine_d;

  logic signed [PROD_W:0]   prod_rnd;
  logic signed [DSUM_W-1:0] swing;
  logic signed [DSUM_W:0]   delay_sum;
  logic [DELAY_W-1:0]       delay_sat;
  logic [ADDR_W-1:0]        k_taps;
  logic [ADDR_W-1:0]        new_addr;

  logic signed [SAMPLE_W:0] diff;
  logic signed [ACC_W-1:0]  acc;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign load_out = (state_q == S_INTERP) && (!out_valid_q || m_axis_tready);

  // Sine lookup from the quarter-wave table.
  always_comb begin
    phase_used = s_axis_tuser[0] ? '0 : lfo_phase_q;
    sine_n     = phase_used[PHASE_W-1 -: SINE_IDX_W];
    quad       = sine_n[SINE_IDX_W-1 -: 2];
    tab_idx    = quad[0] ? ((Q_IDX_W+1)'(QUARTER) - {1'b0, sine_n[Q_IDX_W-1:0]})
                         : {1'b0, sine_n[Q_IDX_W-1:0]};
    sine_mag   = $signed({1'b0, QUARTER_SINE[tab_idx]});
    sine_d     = quad[1] ? -sine_mag : sine_mag;
  end

  // Delay from the registered product, saturated to the usable range.
  always_comb begin
    prod_rnd  = $signed({prod_q[PROD_W-1], prod_q}) + (PROD_W+1)'(1 << 14);
    swing     = DSUM_W'(prod_rnd >>> 15);
    delay_sum = $signed({2'b00, base_delay_q}) + (DSUM_W+1)'(swing);
    if (delay_sum < $signed((DSUM_W+1)'(DELAY_MIN))) begin
      delay_sat = DELAY_W'(DELAY_MIN);
    end else if (delay_sum > $signed((DSUM_W+1)'(DELAY_MAX))) begin
      delay_sat = DELAY_W'(DELAY_MAX);
    end else begin
      delay_sat = DELAY_W'(delay_sum);
    end
    k_taps   = delay_sat[FRAC_W +: ADDR_W];
    new_addr = wp_q - k_taps;
  end

  assign rd_sample = rd_valid_q ? $signed(ram_rd_data) : '0;

  // Interpolation written as newer + (older - newer) * frac.
  always_comb begin
    diff = $signed({rd_sample[SAMPLE_W-1], rd_sample}) - $signed({newer_q[SAMPLE_W-1], newer_q});
    acc  = ($signed(ACC_W'(newer_q)) <<< FRAC_W)
         + ACC_W'(diff * $signed({1'b0, frac_q}))
         + ACC_W'(1 << (FRAC_W - 1));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_MUL;
        end
      end
      S_MUL:      state_d = S_DELAY;
      S_DELAY:    state_d = S_READ_OLD;
      S_READ_OLD: state_d = S_INTERP;
      S_INTERP: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = new_addr;
    ram_we        = 1'b0;
    unique case (state_q)
      S_IDLE:     s_axis_tready = 1'b1;
      S_MUL:      ;
      S_DELAY:    ram_rd_en = 1'b1;
      S_READ_OLD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = old_addr_q;
      end
      S_INTERP:   ram_we = load_out;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_step_q <= '0;
      base_delay_q <= '0;
      mod_depth_q  <= '0;
      lfo_phase_q  <= '0;
      wp_q         <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      rd_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PHASE_STEP: phase_step_q <= cfg_data_i[PHASE_W-1:0];
          CFG_BASE_DELAY: base_delay_q <= cfg_data_i[DEPTH_CFG_W-1:0];
          CFG_MOD_DEPTH:  mod_depth_q  <= cfg_data_i[DEPTH_CFG_W-1:0];
          default:        ;
        endcase
      end
      if (accept) begin
        lfo_phase_q <= phase_used + phase_step_q;
      end
      if (ram_rd_en) begin
        rd_valid_q <= valid_q[ram_rd_addr];
      end
      if (ram_we) begin
        valid_q[wp_q] <= 1'b1;
        wp_q          <= wp_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= s_axis_tdata;
      sine_q   <= sine_d;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(sine_q * $signed({1'b0, mod_depth_q}));
    end
    if (state_q == S_DELAY) begin
      frac_q     <= delay_sat[FRAC_W-1:0];
      old_addr_q <= new_addr - 1'b1;
    end
    if (state_q == S_READ_OLD) begin
      newer_q <= rd_sample;
    end
    if (load_out) begin
      out_data_q <= acc[FRAC_W +: SAMPLE_W];
    end
  end

  vmd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_delay_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (wp_q),
    .wr_data_i (sample_q),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_MUL)
    else $error("Accepted item did not start the multiply step.");

  a_write_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> m_axis_tvalid)
    else $error("Write-back without a result.");

  a_pointer_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> wp_q == ADDR_W'($past(wp_q) + 1'b1))
    else $error("Write pointer did not advance by one.");

  a_taps_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ_OLD |-> ram_rd_addr == ADDR_W'($past(ram_rd_addr) - 1'b1))
    else $error("Older tap is not next to the newer tap.");

endmodule

// ----- design/vmd_ram.sv -----
module vmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import vmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int                   SETTLE_CYCLES  = 12;
  localparam int                   SWEEP_PHASES   = 12;
  localparam int                   SWEEP_ITEMS    = 150;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;
  logic [0:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [SAMPLE_W-1:0]   m_axis_tdata;

  vibrato_modulated_delay_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [SINE_W-2:0]          sine_quarter [QUARTER+1];
  logic signed [SAMPLE_W-1:0] tap_store [BUFFER_DEPTH];
  logic [ADDR_W-1:0]          head_ptr;
  logic [PHASE_W-1:0]         osc_phase;
  logic [PHASE_W-1:0]         osc_step;
  logic [DEPTH_CFG_W-1:0]     center_delay;
  logic [DEPTH_CFG_W-1:0]     swing_depth;

  logic [SAMPLE_W-1:0] pending_samples [$];
  int                  mismatch_count;
  bit                  idle_enable;
  int                  sink_hold_cycles;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic void build_sine_quarter();
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint          acc;
    for (int i = 0; i <= QUARTER; i++) begin
      ang    = (64'(i) * HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
      ang_sq = (ang * ang) >> 30;
      term   = ang;
      acc    = longint'(ang);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) begin
        acc = 0;
      end
      acc = (acc + 16384) >>> 15;
      if (acc > 32767) begin
        acc = 32767;
      end
      sine_quarter[i] = acc[SINE_W-2:0];
    end
  endfunction

  function automatic logic signed [SINE_W-1:0] osc_sine(logic [PHASE_W-1:0] ph);
    logic [SINE_IDX_W-1:0]   pt;
    logic [1:0]              quad;
    logic [Q_IDX_W-1:0]      pos;
    logic signed [SINE_W-1:0] mag;
    pt   = ph[PHASE_W-1 -: SINE_IDX_W];
    quad = pt[SINE_IDX_W-1 -: 2];
    pos  = pt[Q_IDX_W-1:0];
    if (quad[0]) begin
      mag = signed'({1'b0, sine_quarter[QUARTER - int'(pos)]});
    end else begin
      mag = signed'({1'b0, sine_quarter[pos]});
    end
    return quad[1] ? -mag : mag;
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_vibrato_sample(logic [SAMPLE_W-1:0] smp,
                                                               logic restart);
    longint            sine;
    longint            swing;
    longint            dly;
    longint            acc;
    int                k;
    int                f;
    logic [ADDR_W-1:0] tap_new;
    logic [ADDR_W-1:0] tap_old;
    if (restart) begin
      osc_phase = '0;
    end
    sine      = osc_sine(osc_phase);
    osc_phase = osc_phase + osc_step;
    swing     = (sine * longint'(swing_depth) + 16384) >>> 15;
    dly       = longint'(center_delay) + swing;
    if (dly < DELAY_MIN) begin
      dly = DELAY_MIN;
    end
    if (dly > DELAY_MAX) begin
      dly = DELAY_MAX;
    end
    k       = int'(dly >>> FRAC_W);
    f       = int'(dly % 256);
    tap_new = head_ptr - ADDR_W'(k);
    tap_old = tap_new - 1'b1;
    acc     = longint'(tap_store[tap_old]) * f + longint'(tap_store[tap_new]) * (256 - f)
              + 128;
    acc     = acc >>> FRAC_W;
    tap_store[head_ptr] = signed'(smp);
    head_ptr = head_ptr + 1'b1;
    return acc[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_samples.push_back(next_vibrato_sample(s_axis_tdata, s_axis_tuser[0]));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        $error("sample_out: expected none, got %0d", $signed(m_axis_tdata));
        mismatch_count++;
      end else begin
        if (m_axis_tdata !== pending_samples[0]) begin
          $error("sample_out: expected %0d, got %0d", $signed(pending_samples[0]),
                 $signed(m_axis_tdata));
          mismatch_count++;
        end
        void'(pending_samples.pop_front());
      end
    end
  end

  initial begin : result_sink
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_enable ? $urandom_range(0, 3) : 0;
      if (sink_hold_cycles > 0) begin
        stall            = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic restart);
    int gap;
    gap = idle_enable ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_PHASE_STEP: osc_step     = val;
      CFG_BASE_DELAY: center_delay = val[DEPTH_CFG_W-1:0];
      CFG_MOD_DEPTH:  swing_depth  = val[DEPTH_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [PHASE_W-1:0] step, input logic [CFG_DATA_W-1:0] base,
                              input logic [CFG_DATA_W-1:0] depth);
    write_reg(CFG_UNUSED_IDX, $urandom());
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_BASE_DELAY, base);
    write_reg(CFG_MOD_DEPTH, depth);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] noisy_reg(logic [DEPTH_CFG_W-1:0] val);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom();
    word[DEPTH_CFG_W-1:0] = val;
    return word;
  endfunction

  task automatic test_reset_state();
    idle_enable = 1'b1;
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hffff, 1'b1);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h5555, 1'b1);
    drain_stream();
  endtask

  task automatic test_delay_extremes();
    apply_config(32'h0, noisy_reg(14'h3fff), noisy_reg(14'h0));
    repeat (4) push_sample(SAMPLE_W'($urandom()), 1'b0);
    drain_stream();
    apply_config(32'h0, noisy_reg(14'h0180), noisy_reg(14'h0));
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h2aaa, 1'b0);
    drain_stream();
    apply_config(32'h4000_0000, noisy_reg(14'h2000), noisy_reg(14'h3fff));
    push_sample(16'h1234, 1'b1);
    repeat (4) push_sample(SAMPLE_W'($urandom()), 1'b0);
    drain_stream();
    apply_config(32'hffff_ffff, noisy_reg(14'h3fff), noisy_reg(14'h3fff));
    repeat (3) push_sample(SAMPLE_W'($urandom()), 1'b0);
    drain_stream();
    apply_config(32'h8000_0001, noisy_reg(14'h0000), noisy_reg(14'h3fff));
    push_sample(16'h8000, 1'b1);
    repeat (3) push_sample(SAMPLE_W'($urandom()), 1'b0);
    drain_stream();
  endtask

  task automatic test_random_sweeps();
    logic [PHASE_W-1:0]     step;
    logic [DEPTH_CFG_W-1:0] base;
    logic [DEPTH_CFG_W-1:0] depth;
    for (int p = 0; p < SWEEP_PHASES; p++) begin
      case (p)
        0: begin
          step  = '0;
          base  = '0;
          depth = '0;
        end
        1: begin
          step  = '1;
          base  = '1;
          depth = '1;
        end
        2: begin
          step  = 32'd42949673;
          base  = 14'h2000;
          depth = '1;
        end
        3: begin
          step  = $urandom();
          base  = DEPTH_CFG_W'($urandom());
          depth = DEPTH_CFG_W'($urandom());
        end
        default: begin
          step  = $urandom_range(32'd10737418, 32'd214748365);
          base  = DEPTH_CFG_W'($urandom_range(256, 16383));
          depth = DEPTH_CFG_W'($urandom_range(0, 16383));
        end
      endcase
      apply_config(step, noisy_reg(base), noisy_reg(depth));
      idle_enable = (p % 4 != 3);
      for (int i = 0; i < SWEEP_ITEMS; i++) begin
        push_sample(SAMPLE_W'($urandom()), $urandom_range(0, 31) == 0);
      end
      drain_stream();
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_output_backpressure();
    apply_config(32'd85899346, noisy_reg(14'h1800), noisy_reg(14'h1000));
    idle_enable      = 1'b0;
    sink_hold_cycles = 150;
    for (int i = 0; i < 40; i++) begin
      push_sample(SAMPLE_W'($urandom()), 1'b0);
    end
    drain_stream();
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= '0;
    cfg_data_i       <= '0;
    s_axis_tvalid    <= 1'b0;
    s_axis_tdata     <= '0;
    s_axis_tuser     <= '0;
    mismatch_count   = 0;
    idle_enable      = 1'b1;
    sink_hold_cycles = 0;
    build_sine_quarter();
    for (int i = 0; i < BUFFER_DEPTH; i++) begin
      tap_store[i] = '0;
    end
    head_ptr     = '0;
    osc_phase    = '0;
    osc_step     = '0;
    center_delay = '0;
    swing_depth  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_delay_extremes();
    test_random_sweeps();
    test_output_backpressure();

    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/vmd_pkg.sv
design/vmd_ram.sv
design/vibrato_modulated_delay_core.sv
tb/sv/tb.sv
